// File: rtl/assembler_token_lexer_unit_macros.svh
// Assertion macros for the assembler token lexer unit.
// Used by atl_back; depends on nothing.
`ifndef ASSEMBLER_TOKEN_LEXER_UNIT_MACROS_SVH
`define ASSEMBLER_TOKEN_LEXER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ATL_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ATL_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ATL_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define ATL_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: rtl/atl_pkg.sv
// Types, codes and the per-byte lexer step for the assembler token lexer.
// Used by atl_front, atl_back and the top level; depends on nothing.
package atl_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int LENGTH_BITS = 16;
  localparam int QDEPTH      = 4;
  localparam int QAW         = 2;

  localparam logic [3:0] K_IDENT = 4'd0;
  localparam logic [3:0] K_DIR   = 4'd1;
  localparam logic [3:0] K_RELOC = 4'd2;
  localparam logic [3:0] K_LABEL = 4'd3;
  localparam logic [3:0] K_LIT   = 4'd4;
  localparam logic [3:0] K_COMMA = 4'd5;
  localparam logic [3:0] K_PLUS  = 4'd6;
  localparam logic [3:0] K_MINUS = 4'd7;
  localparam logic [3:0] K_OPEN  = 4'd8;
  localparam logic [3:0] K_CLOSE = 4'd9;
  localparam logic [3:0] K_EOL   = 4'd10;
  localparam logic [3:0] K_EOF   = 4'd11;
  localparam logic [3:0] K_ERR   = 4'd12;

  localparam logic [2:0] LK_HEX = 3'd0;
  localparam logic [2:0] LK_BIN = 3'd1;
  localparam logic [2:0] LK_DEC = 3'd2;
  localparam logic [2:0] LK_CHR = 3'd3;
  localparam logic [2:0] LK_STR = 3'd4;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_CHAR = 2'd1;
  localparam logic [1:0] E_OVF  = 2'd2;
  localparam logic [1:0] E_READ = 2'd3;

  localparam logic [1:0] B_HEX = 2'd0;
  localparam logic [1:0] B_BIN = 2'd1;
  localparam logic [1:0] B_DEC = 2'd2;

  typedef enum logic [16:0] {
    M_IDLE   = 17'h00001,
    M_SLASH  = 17'h00002,
    M_LINE   = 17'h00004,
    M_BLOCK  = 17'h00008,
    M_BSTAR  = 17'h00010,
    M_ZERO   = 17'h00020,
    M_HEX    = 17'h00040,
    M_BIN    = 17'h00080,
    M_DEC    = 17'h00100,
    M_DECSFX = 17'h00200,
    M_DOT    = 17'h00400,
    M_PCT    = 17'h00800,
    M_WORD   = 17'h01000,
    M_CHR    = 17'h02000,
    M_CESC   = 17'h04000,
    M_CEND   = 17'h08000,
    M_STR    = 17'h10000
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       rerr;
    logic       alpha;
    logic       digit;
    logic       hexv;
    logic [3:0] hexd;
    logic       print;
  } item_t;

  typedef struct packed {
    mode_t                  mode;
    logic [VALUE_BITS-1:0]  acc;
    logic                   ovf;
    logic [LENGTH_BITS-1:0] len;
    logic [3:0]             pkind;
    logic [2:0]             plk;
  } lex_state_t;

  typedef struct packed {
    logic [3:0]             kind;
    logic [2:0]             lk;
    logic [VALUE_BITS-1:0]  value;
    logic [1:0]             err;
    logic [LENGTH_BITS-1:0] len;
    logic                   last;
  } result_t;

  typedef struct packed {
    lex_state_t st;
    logic       reexam;
    logic       emit;
    result_t    res;
  } step_t;

  localparam logic [VALUE_BITS-1:0]  VMASK = {VALUE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LMAX  = {LENGTH_BITS{1'b1}};

  function automatic lex_state_t reset_state();
    lex_state_t s;
    s.mode  = M_IDLE;
    s.acc   = '0;
    s.ovf   = 1'b0;
    s.len   = '0;
    s.pkind = '0;
    s.plk   = '0;
    return s;
  endfunction

  function automatic item_t classify(logic [7:0] c, logic eoi, logic rerr);
    item_t it;
    it.ch    = c;
    it.eoi   = eoi;
    it.rerr  = rerr;
    it.alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    it.digit = (c >= 8'h30 && c <= 8'h39);
    it.print = (c >= 8'h20 && c <= 8'h7E);
    it.hexv  = 1'b1;
    if (it.digit) it.hexd = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) it.hexd = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) it.hexd = 4'(c - 8'h37);
    else begin
      it.hexd = 4'd0;
      it.hexv = 1'b0;
    end
    return it;
  endfunction

  function automatic result_t mk(logic [3:0] k, logic [2:0] lk, logic [VALUE_BITS-1:0] v,
                                 logic [1:0] e, logic [LENGTH_BITS-1:0] len);
    result_t r;
    r.kind  = k;
    r.lk    = lk;
    r.value = v;
    r.err   = e;
    r.len   = len;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(logic [LENGTH_BITS-1:0] l);
    return (l != LMAX) ? l + 1'b1 : l;
  endfunction

  function automatic lex_state_t start(mode_t m, logic [3:0] k, logic [2:0] lk,
                                       logic [VALUE_BITS-1:0] acc,
                                       logic [LENGTH_BITS-1:0] len);
    lex_state_t s;
    s.mode  = m;
    s.pkind = k;
    s.plk   = lk;
    s.acc   = acc;
    s.ovf   = 1'b0;
    s.len   = len;
    return s;
  endfunction

  // Shift-add multiply by the radix; any bit above the value width flags overflow.
  function automatic lex_state_t accumulate(lex_state_t s, logic [1:0] base, logic [3:0] d);
    lex_state_t n;
    logic [VALUE_BITS+3:0] p;
    n = s;
    case (base)
      B_HEX:   p = {s.acc, 4'b0000} + (VALUE_BITS+4)'(d);
      B_BIN:   p = {3'b000, s.acc, 1'b0} + (VALUE_BITS+4)'(d);
      default: p = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + (VALUE_BITS+4)'(d);
    endcase
    if (p[VALUE_BITS+3:VALUE_BITS] != 4'd0) n.ovf = 1'b1;
    n.acc = p[VALUE_BITS-1:0];
    n.len = len_inc(s.len);
    return n;
  endfunction

  function automatic result_t close_num(lex_state_t s);
    return s.ovf ? mk(K_ERR, s.plk, s.acc, E_OVF, s.len)
                 : mk(K_LIT, s.plk, s.acc, E_NONE, s.len);
  endfunction

  function automatic step_t lex_proc(lex_state_t s, item_t it);
    step_t o;
    logic [7:0] c;
    c = it.ch;
    o.st = s;
    o.reexam = 1'b0;
    o.emit = 1'b0;
    o.res = mk(K_ERR, LK_HEX, '0, E_NONE, '0);
    case (s.mode)
      M_IDLE: begin
        if (it.alpha || c == 8'h40 || c == 8'h5F) begin
          o.st = start(M_WORD, K_IDENT, LK_HEX, '0, LENGTH_BITS'(1));
        end else if (c >= 8'h31 && c <= 8'h39) begin
          o.st = start(M_DECSFX, K_LIT, LK_DEC, VALUE_BITS'(it.hexd), LENGTH_BITS'(1));
        end else begin
          case (c)
            8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: ;
            8'h23: o.st.mode = M_LINE;
            8'h2F: o.st.mode = M_SLASH;
            8'h30: o.st = start(M_ZERO, K_LIT, LK_DEC, '0, LENGTH_BITS'(1));
            8'h2E: o.st = start(M_DOT, K_DIR, LK_HEX, '0, LENGTH_BITS'(1));
            8'h25: o.st = start(M_PCT, K_RELOC, LK_HEX, '0, LENGTH_BITS'(1));
            8'h27: o.st = start(M_CHR, K_LIT, LK_CHR, '0, '0);
            8'h22: o.st = start(M_STR, K_LIT, LK_STR, '0, '0);
            8'h2C: begin o.emit = 1'b1; o.res = mk(K_COMMA, LK_HEX, '0, E_NONE, '0); end
            8'h2B: begin o.emit = 1'b1; o.res = mk(K_PLUS, LK_HEX, '0, E_NONE, '0); end
            8'h2D: begin o.emit = 1'b1; o.res = mk(K_MINUS, LK_HEX, '0, E_NONE, '0); end
            8'h28: begin o.emit = 1'b1; o.res = mk(K_OPEN, LK_HEX, '0, E_NONE, '0); end
            8'h29: begin o.emit = 1'b1; o.res = mk(K_CLOSE, LK_HEX, '0, E_NONE, '0); end
            8'h0A: begin o.emit = 1'b1; o.res = mk(K_EOL, LK_HEX, '0, E_NONE, '0); end
            default: begin
              o.emit = 1'b1;
              o.res = mk(K_ERR, LK_HEX, VALUE_BITS'(c), E_CHAR, '0);
            end
          endcase
        end
      end
      M_SLASH: begin
        if (c == 8'h2F) o.st.mode = M_LINE;
        else if (c == 8'h2A) o.st.mode = M_BLOCK;
        else begin
          o.emit = 1'b1;
          o.res = mk(K_ERR, LK_HEX, VALUE_BITS'(c), E_CHAR, '0);
          o.st.mode = M_IDLE;
        end
      end
      M_LINE: begin
        if (c == 8'h0A) begin
          o.st.mode = M_IDLE;
          o.reexam = 1'b1;
        end
      end
      M_BLOCK: if (c == 8'h2A) o.st.mode = M_BSTAR;
      M_BSTAR: begin
        if (c == 8'h2F) o.st.mode = M_IDLE;
        else if (c != 8'h2A) o.st.mode = M_BLOCK;
      end
      M_ZERO: begin
        if (c == 8'h78 || c == 8'h58) o.st = start(M_HEX, K_LIT, LK_HEX, '0, LENGTH_BITS'(2));
        else if (c == 8'h62 || c == 8'h42)
          o.st = start(M_BIN, K_LIT, LK_BIN, '0, LENGTH_BITS'(2));
        else begin
          o.st.mode = M_DEC;
          o.reexam = 1'b1;
        end
      end
      M_HEX: begin
        if (it.hexv) o.st = accumulate(s, B_HEX, it.hexd);
        else begin
          o.emit = 1'b1;
          o.res = close_num(s);
          o.st.mode = M_IDLE;
          o.reexam = 1'b1;
        end
      end
      M_BIN: begin
        if (c == 8'h30 || c == 8'h31) o.st = accumulate(s, B_BIN, it.hexd);
        else begin
          o.emit = 1'b1;
          o.res = close_num(s);
          o.st.mode = M_IDLE;
          o.reexam = 1'b1;
        end
      end
      M_DEC, M_DECSFX: begin
        if (it.digit) o.st = accumulate(s, B_DEC, it.hexd);
        else if (s.mode == M_DECSFX && (c == 8'h3A || c == 8'h66 || c == 8'h62)) begin
          o.st.len = len_inc(s.len);
          o.emit = 1'b1;
          if (s.ovf) o.res = mk(K_ERR, s.plk, s.acc, E_OVF, o.st.len);
          else o.res = mk((c == 8'h3A) ? K_LABEL : K_IDENT, LK_HEX, s.acc, E_NONE, o.st.len);
          o.st.mode = M_IDLE;
        end else begin
          o.emit = 1'b1;
          o.res = close_num(s);
          o.st.mode = M_IDLE;
          o.reexam = 1'b1;
        end
      end
      M_DOT: begin
        if (it.alpha) begin
          o.st.len = len_inc(s.len);
          o.st.mode = M_WORD;
        end else if (c == 8'h25) begin
          o.st.pkind = K_RELOC;
          o.st.mode = M_PCT;
        end else begin
          o.st.mode = M_WORD;
          o.reexam = 1'b1;
        end
      end
      M_PCT: begin
        o.st.mode = M_WORD;
        if (it.alpha) o.st.len = len_inc(s.len);
        else o.reexam = 1'b1;
      end
      M_WORD: begin
        if (c == 8'h5F || it.alpha || it.digit) o.st.len = len_inc(s.len);
        else begin
          o.st.mode = M_IDLE;
          o.emit = 1'b1;
          if (c == 8'h3A) begin
            o.st.len = len_inc(s.len);
            o.res = mk(K_LABEL, LK_HEX, '0, E_NONE, o.st.len);
          end else begin
            o.res = mk(s.pkind, LK_HEX, '0, E_NONE, s.len);
            o.reexam = 1'b1;
          end
        end
      end
      M_CHR: begin
        o.st.mode = M_CEND;
        if (c == 8'h5C) begin
          o.st.len = LENGTH_BITS'(1);
          o.st.mode = M_CESC;
        end else if (it.print) begin
          o.st.acc = VALUE_BITS'(c);
          o.st.len = LENGTH_BITS'(1);
        end else begin
          o.st.acc = '0;
          o.st.len = '0;
        end
      end
      M_CESC: begin
        if (c == 8'h6E) begin
          o.st.acc = VALUE_BITS'(8'h0A);
          o.st.len = LENGTH_BITS'(2);
        end else begin
          o.st.pkind = K_ERR;
          o.st.acc = VALUE_BITS'(c);
        end
        o.st.mode = M_CEND;
      end
      M_CEND: begin
        o.emit = 1'b1;
        if (c != 8'h27) o.res = mk(K_ERR, LK_HEX, VALUE_BITS'(c), E_CHAR, '0);
        else if (s.pkind == K_ERR) o.res = mk(K_ERR, LK_HEX, s.acc, E_CHAR, '0);
        else o.res = mk(K_LIT, LK_CHR, s.acc, E_NONE, s.len);
        o.st.mode = M_IDLE;
      end
      M_STR: begin
        if (c == 8'h22) begin
          o.emit = 1'b1;
          o.res = mk(K_LIT, LK_STR, s.acc + 1'b1, E_NONE, s.len);
          o.st.mode = M_IDLE;
        end else if (it.print) begin
          o.st.len = len_inc(s.len);
          if (s.acc < VMASK - 1'b1) o.st.acc = s.acc + 1'b1;
        end else begin
          o.emit = 1'b1;
          o.res = mk(K_ERR, LK_HEX, VALUE_BITS'(c), E_CHAR, '0);
          o.st.mode = M_IDLE;
        end
      end
      default: begin
        o.st.mode = M_IDLE;
        o.reexam = 1'b1;
      end
    endcase
    return o;
  endfunction

  // Flush of an open token at end of input; only emit and res are meaningful.
  function automatic step_t close_open(lex_state_t s);
    step_t o;
    o.st = s;
    o.reexam = 1'b0;
    o.emit = 1'b1;
    o.res = mk(K_ERR, LK_HEX, '0, E_CHAR, '0);
    case (s.mode)
      M_SLASH: o.res = mk(K_ERR, LK_HEX, VALUE_BITS'(8'h2F), E_CHAR, '0);
      M_ZERO, M_HEX, M_BIN, M_DEC, M_DECSFX: o.res = close_num(s);
      M_DOT, M_PCT, M_WORD: o.res = mk(s.pkind, LK_HEX, '0, E_NONE, s.len);
      M_CHR, M_CESC, M_CEND: o.res = mk(K_ERR, LK_HEX, '0, E_CHAR, '0);
      M_STR: o.res = mk(K_LIT, LK_STR, s.acc + 1'b1, E_NONE, s.len);
      default: o.emit = 1'b0;
    endcase
    return o;
  endfunction

endpackage

// File: rtl/atl_front.sv
// Front end: accepts source words, classifies each byte and queues it.
// Depends on atl_pkg.
module atl_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_char,
  input  logic           in_eoi,
  input  logic           in_rerr,
  output logic           q_valid,
  output atl_pkg::item_t q_item,
  input  logic           q_pop
);

  atl_pkg::item_t           mem_r [atl_pkg::QDEPTH];
  logic [atl_pkg::QAW-1:0]  wp_r, rp_r;
  logic [atl_pkg::QAW:0]    cnt_r, cnt_nxt;
  logic                     push;

  assign in_ready = (cnt_r != (atl_pkg::QAW+1)'(atl_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= atl_pkg::classify(in_char, in_eoi, in_rerr);
  end

endmodule

// File: rtl/atl_back.sv
// Back end: runs the lexer state machine on queued bytes and holds results.
// Depends on atl_pkg and assembler_token_lexer_unit_macros.svh.
`include "assembler_token_lexer_unit_macros.svh"
module atl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  atl_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output atl_pkg::result_t out_res
);

  atl_pkg::lex_state_t st_r, st_nxt;
  atl_pkg::result_t    r0_r, r1_r, res0, res1;
  logic                out_v_r, sec_v_r;
  logic [1:0]          n;
  logic                more;
  atl_pkg::step_t      stp, cls;

  // Up to three passes: a byte that ends a token is re-examined in the new mode.
  always_comb begin
    st_nxt = st_r;
    n      = 2'd0;
    more   = 1'b1;
    res0   = atl_pkg::mk(atl_pkg::K_EOF, atl_pkg::LK_HEX, '0, atl_pkg::E_NONE, '0);
    res1   = res0;
    stp    = '0;
    cls    = atl_pkg::close_open(st_r);
    if (q_item.eoi) begin
      if (cls.emit) begin
        res0 = cls.res;
        n    = 2'd1;
      end
      if (q_item.rerr)
        res1 = atl_pkg::mk(atl_pkg::K_ERR, atl_pkg::LK_HEX, '0, atl_pkg::E_READ, '0);
      if (n == 2'd0) res0 = res1;
      n = n + 2'd1;
      st_nxt = atl_pkg::reset_state();
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (more) begin
          stp    = atl_pkg::lex_proc(st_nxt, q_item);
          st_nxt = stp.st;
          if (stp.emit) begin
            if (n == 2'd0) begin
              res0 = stp.res;
              n    = 2'd1;
            end else if (n == 2'd1) begin
              res1 = stp.res;
              n    = 2'd2;
            end
          end
          more = stp.reexam;
        end
      end
    end
    res0.last = (n == 2'd1);
    res1.last = 1'b1;
  end

  assign q_pop     = q_valid && (!out_v_r || (out_ready && !sec_v_r));
  assign out_valid = out_v_r;
  assign out_res   = r0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= atl_pkg::reset_state();
      out_v_r <= 1'b0;
      sec_v_r <= 1'b0;
    end else if (q_pop) begin
      st_r    <= st_nxt;
      out_v_r <= (n != 2'd0);
      sec_v_r <= (n == 2'd2);
    end else if (out_v_r && out_ready) begin
      out_v_r <= sec_v_r;
      sec_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      r0_r <= res0;
      r1_r <= res1;
    end else if (out_v_r && out_ready && sec_v_r) begin
      r0_r <= r1_r;
    end
  end

  `ATL_ASSERT_IMP(a_sec_needs_first, clk, rst_n, sec_v_r, out_v_r)
  `ATL_ASSERT_IMP(a_sec_first_not_last, clk, rst_n, sec_v_r, !r0_r.last)
  `ATL_ASSERT_NXT(a_sec_moves_up, clk, rst_n, sec_v_r && out_ready, out_v_r && !sec_v_r)

endmodule

// File: rtl/assembler_token_lexer_unit.sv
// Assembler token lexer: one source byte per word in, one token per word out.
// Each accepted byte is written to the byte queue, then its results to the output register.
// Throughput: one byte per cycle while the output is not stalled; a byte that yields two
// tokens holds off the next byte until both are taken, absorbed by the four-entry byte queue.
// Reset (rst_n low, synchronous): lexer idle, queue and output registers empty.
// Depends on atl_pkg, atl_front and atl_back.
module assembler_token_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_input
  input  logic [0:0]  in_tuser,   // [0] read_error
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] token_value, [47:32] token_length
  output logic        out_tlast,  // last_of_run
  output logic [8:0]  out_tuser   // [3:0] token_kind, [6:4] literal_kind, [8:7] error_cause
);

  logic             q_valid, q_pop;
  atl_pkg::item_t   q_item;
  atl_pkg::result_t res;

  // Accept and classify bytes; the queue lets the front keep taking words
  // while the back drains a two-token byte.
  atl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .in_eoi   (in_tlast),
    .in_rerr  (in_tuser[0]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Advance the lexer and hold up to two result words per byte.
  atl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.len, res.value};
  assign out_tlast = res.last;
  assign out_tuser = {res.err, res.lk, res.kind};

endmodule

// File: test/tb_assembler_token_lexer_unit.sv
// Testbench for assembler_token_lexer_unit: drives source bytes with random
// gaps and output stalls, predicts every token and compares all of its fields.
// Depends on atl_pkg for the token, literal and error codes.
module tb_assembler_token_lexer_unit;

  // Local lexer modes of the predictor.
  typedef enum int {
    L_IDLE, L_SLASH, L_LINE, L_BLOCK, L_BSTAR, L_ZERO, L_HEX, L_BIN, L_DEC,
    L_DECSFX, L_DOT, L_PCT, L_WORD, L_CHR, L_CESC, L_CEND, L_STR
  } lex_mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  lk;
    logic [31:0] value;
    logic [1:0]  err;
    logic [15:0] len;
    logic        last;
  } token_t;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic [8:0]  out_tuser;

  assembler_token_lexer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // Predictor state.
  lex_mode_t   lx_mode;
  logic [31:0] lx_acc;
  logic        lx_ovf;
  logic [15:0] lx_len;
  logic [3:0]  lx_pkind;
  logic [2:0]  lx_plk;

  token_t token_q[$];
  token_t step_toks[$];
  int     mismatches;
  int     cycles;
  bit     no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run with a failure once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL assembler_token_lexer_unit");
      $finish;
    end
  end

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_print(logic [7:0] c);
    return c >= 8'h20 && c <= 8'h7E;
  endfunction

  function automatic void emit_token(logic [3:0] k, logic [2:0] lk, logic [31:0] v,
                                     logic [1:0] e, logic [15:0] len);
    token_t t;
    t.kind = k; t.lk = lk; t.value = v; t.err = e; t.len = len; t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void bump_len();
    if (lx_len != 16'hFFFF) lx_len = lx_len + 16'd1;
  endfunction

  function automatic void open_token(lex_mode_t m, logic [3:0] k, logic [2:0] lk,
                                     logic [31:0] acc, logic [15:0] len);
    lx_mode = m; lx_pkind = k; lx_plk = lk; lx_acc = acc; lx_ovf = 1'b0; lx_len = len;
  endfunction

  // Multiply-add at the literal radix; anything above 32 bits flags overflow.
  function automatic void add_digit(int radix, int d);
    logic [63:0] p;
    p = {32'd0, lx_acc} * 64'(radix) + 64'(d);
    if (p[63:32] != 32'd0) lx_ovf = 1'b1;
    lx_acc = p[31:0];
    bump_len();
  endfunction

  function automatic void close_literal();
    if (lx_ovf) emit_token(atl_pkg::K_ERR, lx_plk, lx_acc, atl_pkg::E_OVF, lx_len);
    else emit_token(atl_pkg::K_LIT, lx_plk, lx_acc, atl_pkg::E_NONE, lx_len);
    lx_mode = L_IDLE;
  endfunction

  function automatic void clear_lexer();
    lx_mode = L_IDLE; lx_acc = '0; lx_ovf = 1'b0; lx_len = '0; lx_pkind = '0; lx_plk = '0;
  endfunction

  function automatic void punct(logic [3:0] k);
    emit_token(k, atl_pkg::LK_HEX, 32'd0, atl_pkg::E_NONE, 16'd0);
  endfunction

  function automatic void char_error(logic [31:0] v);
    emit_token(atl_pkg::K_ERR, atl_pkg::LK_HEX, v, atl_pkg::E_CHAR, 16'd0);
  endfunction

  // One pass of a byte through the lexer; returns 1 to look at the byte again.
  function automatic bit lex_byte(logic [7:0] c);
    int h;
    case (lx_mode)
      L_IDLE: begin
        if (is_alpha(c) || c == "@" || c == "_")
          open_token(L_WORD, atl_pkg::K_IDENT, atl_pkg::LK_HEX, 32'd0, 16'd1);
        else if (c >= "1" && c <= "9")
          open_token(L_DECSFX, atl_pkg::K_LIT, atl_pkg::LK_DEC, 32'(c - "0"), 16'd1);
        else case (c)
          8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: ;
          "#": lx_mode = L_LINE;
          "/": lx_mode = L_SLASH;
          "0": open_token(L_ZERO, atl_pkg::K_LIT, atl_pkg::LK_DEC, 32'd0, 16'd1);
          ".": open_token(L_DOT, atl_pkg::K_DIR, atl_pkg::LK_HEX, 32'd0, 16'd1);
          "%": open_token(L_PCT, atl_pkg::K_RELOC, atl_pkg::LK_HEX, 32'd0, 16'd1);
          "'": open_token(L_CHR, atl_pkg::K_LIT, atl_pkg::LK_CHR, 32'd0, 16'd0);
          "\"": open_token(L_STR, atl_pkg::K_LIT, atl_pkg::LK_STR, 32'd0, 16'd0);
          ",": punct(atl_pkg::K_COMMA);
          "+": punct(atl_pkg::K_PLUS);
          "-": punct(atl_pkg::K_MINUS);
          "(": punct(atl_pkg::K_OPEN);
          ")": punct(atl_pkg::K_CLOSE);
          8'h0A: punct(atl_pkg::K_EOL);
          default: char_error(32'(c));
        endcase
        return 0;
      end
      L_SLASH: begin
        if (c == "/") lx_mode = L_LINE;
        else if (c == "*") lx_mode = L_BLOCK;
        else begin
          char_error(32'(c));
          lx_mode = L_IDLE;
        end
        return 0;
      end
      L_LINE: begin
        if (c == 8'h0A) begin
          lx_mode = L_IDLE;
          return 1;
        end
        return 0;
      end
      L_BLOCK: begin
        if (c == "*") lx_mode = L_BSTAR;
        return 0;
      end
      L_BSTAR: begin
        if (c == "/") lx_mode = L_IDLE;
        else if (c != "*") lx_mode = L_BLOCK;
        return 0;
      end
      L_ZERO: begin
        if (c == "x" || c == "X") begin
          open_token(L_HEX, atl_pkg::K_LIT, atl_pkg::LK_HEX, 32'd0, 16'd2);
          return 0;
        end
        if (c == "b" || c == "B") begin
          open_token(L_BIN, atl_pkg::K_LIT, atl_pkg::LK_BIN, 32'd0, 16'd2);
          return 0;
        end
        lx_mode = L_DEC;
        return 1;
      end
      L_HEX: begin
        if (is_digit(c)) h = int'(c) - 48;
        else if (c >= "a" && c <= "f") h = int'(c) - 87;
        else if (c >= "A" && c <= "F") h = int'(c) - 55;
        else h = -1;
        if (h >= 0) begin
          add_digit(16, h);
          return 0;
        end
        close_literal();
        return 1;
      end
      L_BIN: begin
        if (c == "0" || c == "1") begin
          add_digit(2, int'(c) - 48);
          return 0;
        end
        close_literal();
        return 1;
      end
      L_DEC, L_DECSFX: begin
        if (is_digit(c)) begin
          add_digit(10, int'(c) - 48);
          return 0;
        end
        if (lx_mode == L_DECSFX && (c == ":" || c == "f" || c == "b")) begin
          bump_len();
          if (lx_ovf) emit_token(atl_pkg::K_ERR, lx_plk, lx_acc, atl_pkg::E_OVF, lx_len);
          else emit_token(c == ":" ? atl_pkg::K_LABEL : atl_pkg::K_IDENT, atl_pkg::LK_HEX,
                          lx_acc, atl_pkg::E_NONE, lx_len);
          lx_mode = L_IDLE;
          return 0;
        end
        close_literal();
        return 1;
      end
      L_DOT: begin
        if (is_alpha(c)) begin
          bump_len();
          lx_mode = L_WORD;
          return 0;
        end
        if (c == "%") begin
          lx_pkind = atl_pkg::K_RELOC;
          lx_mode = L_PCT;
          return 0;
        end
        lx_mode = L_WORD;
        return 1;
      end
      L_PCT: begin
        lx_mode = L_WORD;
        if (is_alpha(c)) begin
          bump_len();
          return 0;
        end
        return 1;
      end
      L_WORD: begin
        if (c == "_" || is_alpha(c) || is_digit(c)) begin
          bump_len();
          return 0;
        end
        lx_mode = L_IDLE;
        if (c == ":") begin
          bump_len();
          emit_token(atl_pkg::K_LABEL, atl_pkg::LK_HEX, 32'd0, atl_pkg::E_NONE, lx_len);
          return 0;
        end
        emit_token(lx_pkind, atl_pkg::LK_HEX, 32'd0, atl_pkg::E_NONE, lx_len);
        return 1;
      end
      L_CHR: begin
        if (c == "\\") begin
          lx_len = 16'd1;
          lx_mode = L_CESC;
        end else if (is_print(c)) begin
          lx_acc = 32'(c); lx_len = 16'd1; lx_mode = L_CEND;
        end else begin
          lx_acc = 32'd0; lx_len = 16'd0; lx_mode = L_CEND;
        end
        return 0;
      end
      L_CESC: begin
        if (c == "n") begin
          lx_acc = 32'h0A; lx_len = 16'd2;
        end else begin
          lx_pkind = atl_pkg::K_ERR; lx_acc = 32'(c);
        end
        lx_mode = L_CEND;
        return 0;
      end
      L_CEND: begin
        if (c != "'") char_error(32'(c));
        else if (lx_pkind == atl_pkg::K_ERR) char_error(lx_acc);
        else emit_token(atl_pkg::K_LIT, atl_pkg::LK_CHR, lx_acc, atl_pkg::E_NONE, lx_len);
        lx_mode = L_IDLE;
        return 0;
      end
      default: begin
        if (c == "\"") begin
          emit_token(atl_pkg::K_LIT, atl_pkg::LK_STR, lx_acc + 32'd1, atl_pkg::E_NONE, lx_len);
          lx_mode = L_IDLE;
        end else if (is_print(c)) begin
          bump_len();
          if (lx_acc < 32'hFFFF_FFFE) lx_acc = lx_acc + 32'd1;
        end else begin
          char_error(32'(c));
          lx_mode = L_IDLE;
        end
        return 0;
      end
    endcase
  endfunction

  // Work out the tokens of one accepted word and queue them.
  function automatic void predict_tokens(logic [7:0] c, bit eoi, bit rerr);
    token_t t;
    step_toks.delete();
    if (eoi) begin
      case (lx_mode)
        L_SLASH: char_error(32'h2F);
        L_ZERO, L_HEX, L_BIN, L_DEC, L_DECSFX: close_literal();
        L_DOT, L_PCT, L_WORD:
          emit_token(lx_pkind, atl_pkg::LK_HEX, 32'd0, atl_pkg::E_NONE, lx_len);
        L_CHR, L_CESC, L_CEND: char_error(32'd0);
        L_STR:
          emit_token(atl_pkg::K_LIT, atl_pkg::LK_STR, lx_acc + 32'd1, atl_pkg::E_NONE, lx_len);
        default: ;
      endcase
      if (rerr) emit_token(atl_pkg::K_ERR, atl_pkg::LK_HEX, 32'd0, atl_pkg::E_READ, 16'd0);
      else punct(atl_pkg::K_EOF);
      clear_lexer();
    end else begin
      for (int i = 0; i < 3; i++)
        if (!lex_byte(c)) break;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) begin
      t = step_toks[i];
      token_q.push_back(t);
    end
  endfunction

  // Send one word; hold it until accepted, then predict its tokens.
  task automatic send_word(logic [7:0] c, bit eoi = 0, bit rerr = 0);
    if (!no_idle) begin
      while ($urandom_range(99) < 28) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eoi;
    in_tuser  <= rerr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tokens(c, eoi, rerr);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  // Drop valid and hold the sender until every expected token has drained.
  task automatic drain_tokens();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (token_q.size() != 0) @(negedge clk);
  endtask

  // Receiver: stall at random and check each accepted token.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser[3:0]; got.lk = out_tuser[6:4]; got.err = out_tuser[8:7];
      got.value = out_tdata[31:0]; got.len = out_tdata[47:32]; got.last = out_tlast;
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token %p", got);
      end else begin
        want = token_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("token mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_text("mov a0, 0x1F(sp)\n");
    send_text(".text %hi(x) .%lo .9 %% lbl: 0b101 0x 0b 0xFFFFFFFF 0x100000000\n");
    send_text("99999999999 4294967295 1: 12f 3b 07 0f\n");
    send_text("'a' '\\n' '\\t' 'ab '\x01' \"hi\" \"x\x02 / /x");
    send_text("# c\n// c\n/* \n ** */ ~\xFF\x80");
    send_word(8'h00);
    send_word(8'h00, 1, 0);
    send_text("\"open");
    send_word(8'hFF, 1, 1);
    send_text("'");
    send_word(8'h00, 1, 0);
    send_text("/");
    send_word(8'h00, 1, 0);
  endtask

  // Random source built mostly from fragments of assembler text, some of them malformed.
  task automatic test_random(int n);
    string frags[$] = '{"add ", "x1", ", ", "0x", "0b", ".word ", "%pcrel_hi(", ")",
                        "label: ", "1:", "1f", "2b", "'", "'\\n'", "\"str\"", "\"",
                        "# note\n", "// c\n", "/* a*b **/", "+", "-", "\n", "123",
                        "4294967296", "0xDEADbeef", "\\", ".%", "_@"};
    int sent;
    bit drained;
    string s;
    sent = 0;
    drained = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 7) begin
        s = frags[$urandom_range(frags.size() - 1)];
        send_text(s);
        sent += s.len();
      end else if ($urandom_range(39) == 0) begin
        send_word(8'($urandom), 1, $urandom_range(1));
        sent++;
      end else begin
        send_word(8'($urandom));
        sent++;
      end
      if (!drained && sent > n / 2) begin
        drain_tokens();
        drained = 1;
        no_idle = 1;
      end
      if (sent > n / 2 + 200) no_idle = 0;
    end
    send_word(8'h00, 1, 0);
  endtask

  initial begin
    no_idle = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    in_tuser = '0;
    clear_lexer();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(1160);
    drain_tokens();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("PASS assembler_token_lexer_unit");
    else $display("FAIL assembler_token_lexer_unit");
    $finish;
  end

endmodule

// File: assembler_token_lexer_unit.f
+incdir+rtl
rtl/atl_pkg.sv
rtl/atl_front.sv
rtl/atl_back.sv
rtl/assembler_token_lexer_unit.sv
test/tb_assembler_token_lexer_unit.sv
